// ----- src/tdrc_pkg.sv -----
// Shared types, constants and register codes for the tachometer speed controller.
package tdrc_pkg;

	localparam int unsigned SAMPLES_DEF = 10;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned SUM_W = 22;
	localparam int unsigned RPM_W = 16;
	localparam int unsigned DUTY_W = 14;
	localparam int unsigned TARGET_W = 8;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned FIFO_DEPTH = 2;

	localparam logic [SUM_W-1:0] RPM_NUMERATOR = SUM_W'(2000000);
	localparam logic [RPM_W-1:0] RPM_MAX = 16'hFFFF;
	localparam logic [TARGET_W:0] DEADBAND = 9'd3;
	localparam logic [DUTY_W-1:0] DUTY_STEP = 14'd100;
	localparam logic [DUTY_W-1:0] DUTY_LOW = 14'd100;
	localparam logic [DUTY_W-1:0] DUTY_HIGH = 14'd14898;
	localparam logic [DUTY_W-1:0] DUTY_RESET = 14'd3750;
	localparam logic [DUTY_W-1:0] DUTY_MAX = 14'd14999;
	localparam logic [TARGET_W-1:0] TARGET_RESET = 8'd50;

	localparam logic [CFG_IDX_W-1:0] REG_DESIRED_LEFT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DESIRED_RIGHT = 8'd1;

	typedef struct packed {
		logic [PERIOD_W-1:0] left_period;
		logic [PERIOD_W-1:0] right_period;
	} in_item_t;

	typedef struct packed {
		logic [RPM_W-1:0]  rpm_left;
		logic [RPM_W-1:0]  rpm_right;
		logic [DUTY_W-1:0] duty_left;
		logic [DUTY_W-1:0] duty_right;
	} out_item_t;

	// One finished block of samples, handed from the front to the back.
	typedef struct packed {
		logic [SUM_W-1:0] sum_left;
		logic [SUM_W-1:0] sum_right;
	} sums_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_AVG,
		BK_RPM,
		BK_DONE
	} back_state_t;

endpackage

// ----- src/tdrc_front.sv -----
// Front end: accepts period pairs, accumulates them and emits one sum pair per block.
module tdrc_front import tdrc_pkg::*; #(
	parameter int unsigned SAMPLES = SAMPLES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  in_item_t in_data,
	input  logic     queue_full,
	output logic     in_stall,
	output logic     push,
	output sums_t    push_data
);

	localparam int unsigned CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

	logic [SUM_W-1:0] sum_l_q, sum_r_q;
	logic [SUM_W-1:0] sum_l_n, sum_r_n;
	logic [CNT_W-1:0] cnt_q;
	logic             accept, last;

	assign in_stall = queue_full;
	assign accept = in_valid & ~queue_full;
	assign last = (cnt_q == CNT_W'(SAMPLES - 1));
	assign sum_l_n = sum_l_q + SUM_W'(in_data.left_period);
	assign sum_r_n = sum_r_q + SUM_W'(in_data.right_period);

	assign push = accept & last;
	assign push_data = '{sum_left: sum_l_n, sum_right: sum_r_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_l_q <= '0;
			sum_r_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (last) begin
				sum_l_q <= '0;
				sum_r_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_l_q <= sum_l_n;
				sum_r_q <= sum_r_n;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

// ----- src/tdrc_fifo.sv -----
// Short queue of finished sum pairs between the front and the back.
module tdrc_fifo import tdrc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  sums_t        push_data,
	input  logic         pop,
	output sums_t        head,
	output fifo_status_t status
);

	localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

	sums_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign status.full = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- src/tdrc_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module tdrc_div import tdrc_pkg::*; #(
	parameter int unsigned W = SUM_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic [W-1:0] quotient,
	output logic         done
);

	localparam int unsigned CNT_W = (W > 1) ? $clog2(W) : 1;

	logic [W-1:0]     dvd_q, dvs_q, rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [W:0]       shifted, diff;
	logic             fits;

	assign shifted = {rem_q, dvd_q[W-1]};
	assign diff = shifted - {1'b0, dvs_q};
	assign fits = (shifted >= {1'b0, dvs_q});
	assign quotient = dvd_q;
	assign done = done_q;

	// The quotient bits shift into the dividend register as its bits leave.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[W-2:0], fits};
			rem_q <= fits ? diff[W-1:0] : shifted[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

// ----- src/tdrc_back.sv -----
// Back end: averages, converts to rpm, steps the duties and holds the result.
module tdrc_back import tdrc_pkg::*; #(
	parameter int unsigned SAMPLES = SAMPLES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fifo_status_t        q_status,
	input  sums_t               q_head,
	input  logic [TARGET_W-1:0] target_left,
	input  logic [TARGET_W-1:0] target_right,
	output logic                pop,
	output logic                busy,
	output logic                out_valid,
	input  logic                out_stall,
	output out_item_t           out_data
);

	// The average is the sum times a rounded-up reciprocal of SAMPLES, shifted down.
	// With the shift set to the sum width plus the bits of SAMPLES it is exact for every sum.
	localparam int unsigned AVG_SHIFT = SUM_W + $clog2(SAMPLES);
	localparam logic [SUM_W:0] AVG_MUL =
		(SUM_W + 1)'(((64'd1 << AVG_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));
	localparam int unsigned PROD_W = 2 * SUM_W + 1;

	back_state_t       state_q, state_n;
	logic              div_start, load_out;
	logic [PROD_W-1:0] prod_l, prod_r;
	logic [SUM_W-1:0]  quo_l, quo_r;
	logic              done_l, done_r;
	logic [SUM_W-1:0]  avg_l_q, avg_r_q;
	logic [RPM_W-1:0]  rpm_l_q, rpm_r_q;
	logic [DUTY_W-1:0] duty_l_q, duty_r_q, duty_l_n, duty_r_n;
	logic              out_valid_q;
	out_item_t         out_q;

	function automatic logic [RPM_W-1:0] saturate(input logic [SUM_W-1:0] avg,
			input logic [SUM_W-1:0] quo);
		logic [RPM_W-1:0] r;
		if (avg == '0 || quo > SUM_W'(RPM_MAX)) begin
			r = RPM_MAX;
		end else begin
			r = quo[RPM_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [DUTY_W-1:0] next_duty(input logic [DUTY_W-1:0] duty,
			input logic [RPM_W-1:0] rpm, input logic [TARGET_W-1:0] target);
		logic [RPM_W:0]    rpm_x, tgt_x;
		logic [DUTY_W-1:0] d;
		rpm_x = {1'b0, rpm};
		tgt_x = (RPM_W + 1)'(target);
		d = duty;
		if (rpm_x > tgt_x + (RPM_W + 1)'(DEADBAND) && duty > DUTY_LOW) begin
			d = duty - DUTY_STEP;
		end else if (rpm_x + (RPM_W + 1)'(DEADBAND) < tgt_x && duty < DUTY_HIGH) begin
			d = duty + DUTY_STEP;
		end
		return d;
	endfunction

	assign prod_l = PROD_W'(q_head.sum_left) * PROD_W'(AVG_MUL);
	assign prod_r = PROD_W'(q_head.sum_right) * PROD_W'(AVG_MUL);

	tdrc_div #(.W(SUM_W)) u_div_l (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(RPM_NUMERATOR),
		.divisor (avg_l_q),
		.quotient(quo_l),
		.done    (done_l)
	);

	tdrc_div #(.W(SUM_W)) u_div_r (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(RPM_NUMERATOR),
		.divisor (avg_r_q),
		.quotient(quo_r),
		.done    (done_r)
	);

	// Both lanes start together and take the same number of steps.
	always_comb begin
		state_n = state_q;
		case (state_q)
			BK_IDLE: if (!q_status.empty) state_n = BK_AVG;
			BK_AVG: state_n = BK_RPM;
			BK_RPM: if (done_l && done_r) state_n = BK_DONE;
			BK_DONE: if (!out_valid_q || !out_stall) state_n = BK_IDLE;
			default: state_n = BK_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		div_start = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: pop = !q_status.empty;
			BK_AVG: div_start = 1'b1;
			BK_RPM: begin
			end
			BK_DONE: load_out = !out_valid_q || !out_stall;
			default: begin
			end
		endcase
	end

	assign duty_l_n = next_duty(duty_l_q, rpm_l_q, target_left);
	assign duty_r_n = next_duty(duty_r_q, rpm_r_q, target_right);
	assign busy = (state_q != BK_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			avg_l_q <= SUM_W'(prod_l >> AVG_SHIFT);
			avg_r_q <= SUM_W'(prod_r >> AVG_SHIFT);
		end
		if (state_q == BK_RPM && done_l && done_r) begin
			rpm_l_q <= saturate(avg_l_q, quo_l);
			rpm_r_q <= saturate(avg_r_q, quo_r);
		end
		if (load_out) begin
			out_q <= '{rpm_left: rpm_l_q, rpm_right: rpm_r_q,
				duty_left: duty_l_n, duty_right: duty_r_n};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			out_valid_q <= 1'b0;
			duty_l_q <= DUTY_RESET;
			duty_r_q <= DUTY_RESET;
		end else begin
			state_q <= state_n;
			if (load_out) begin
				out_valid_q <= 1'b1;
				duty_l_q <= duty_l_n;
				duty_r_q <= duty_r_n;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- src/tacho_rpm_deadband_duty_controller_unit.sv -----
// Top level of the tachometer speed controller: config registers, front, queue and back.
// An item that does not complete a block is absorbed into the sums and yields no result;
// one input transaction per cycle is taken while the queue has room. out_valid rises once
// the completing transaction has passed queue read with a reciprocal-multiply average,
// division start, 22 divider steps, rpm capture and output load, one block at a time.
// The asynchronous reset clears sums, counts, queue and out_valid; duties 3750, targets 50.
module tacho_rpm_deadband_duty_controller_unit import tdrc_pkg::*; #(
	parameter int unsigned SAMPLES = SAMPLES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [TARGET_W-1:0] target_left_q, target_right_q;
	logic                push, pop, back_busy;
	sums_t               push_data, q_head;
	fifo_status_t        q_status;

	// Configuration writes are never held off. Software must write the targets only
	// while the block is idle to avoid a hazard with a computation in flight; the
	// block does not enforce this. Writes to other indexes complete and are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_left_q <= TARGET_RESET;
			target_right_q <= TARGET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DESIRED_LEFT: target_left_q <= cfg_data[TARGET_W-1:0];
				REG_DESIRED_RIGHT: target_right_q <= cfg_data[TARGET_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The front accumulates period pairs and hands each finished block's sums on.
	tdrc_front #(.SAMPLES(SAMPLES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.queue_full(q_status.full),
		.in_stall  (in_stall),
		.push      (push),
		.push_data (push_data)
	);

	// The queue lets the front keep taking samples while the back is still dividing
	// or while a finished result waits on a stalled output.
	tdrc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (q_head),
		.status   (q_status)
	);

	// The back runs the divisions, applies the deadband step to each duty and
	// holds the result in its output register until the receiver takes it.
	tdrc_back #(.SAMPLES(SAMPLES)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_status    (q_status),
		.q_head      (q_head),
		.target_left (target_left_q),
		.target_right(target_right_q),
		.pop         (pop),
		.busy        (back_busy),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

	// A new block is taken from the queue only when the back is idle.
	always_comb begin
		if (pop && back_busy) begin
			$error("queue read while the back end is busy");
		end
	end

endmodule

// ----- src/tdrc_checker.sv -----
// Port-level checker for the speed controller, bound to the top level.
module tdrc_checker import tdrc_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input in_item_t              in_data,
	input logic                  out_valid,
	input logic                  out_stall,
	input out_item_t             out_data,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("stalled result changed");

	// Any average fits in 16 bits, so the speed can never fall below 30 rpm.
	a_rpm_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.rpm_left >= 16'd30 && out_data.rpm_right >= 16'd30)
		else $error("rpm below the reachable minimum");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.duty_left <= DUTY_MAX && out_data.duty_right <= DUTY_MAX)
		else $error("duty outside the PWM range");

endmodule

bind tacho_rpm_deadband_duty_controller_unit tdrc_checker u_tdrc_checker (.*);

// ----- verif/tacho_rpm_deadband_duty_controller_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the tachometer speed controller with deadband duty stepping.
module tacho_rpm_deadband_duty_controller_unit_tb;
	import tdrc_pkg::*;

	// A stretch this long with no transaction on any channel means the block hung.
	// The worst correct stretch is a full queue behind one computation of the back end and
	// an output stall burst, plus the settling pause, so this leaves a wide margin.
	localparam int unsigned QUIET_LIMIT = 2000;
	// Pause after the last awaited report, covering one full computation of the back end.
	localparam int unsigned SETTLE_CYCLES = 64;

	// How the periods of one wheel are drawn for one block of samples.
	typedef enum int {
		AIM_DEADBAND,
		AIM_ANY,
		AIM_TINY,
		AIM_SLOW
	} aim_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow copy of the controller state, advanced at each accepted input transaction.
	logic [SUM_W-1:0]    acc_left = '0;
	logic [SUM_W-1:0]    acc_right = '0;
	int unsigned         fill_count = 0;
	logic [DUTY_W-1:0]   duty_left_now = DUTY_RESET;
	logic [DUTY_W-1:0]   duty_right_now = DUTY_RESET;
	logic [TARGET_W-1:0] target_left = TARGET_RESET;
	logic [TARGET_W-1:0] target_right = TARGET_RESET;
	out_item_t           due_reports[$];

	// Odds of an idle burst: one in N per transaction or cycle, zero turns bursts off.
	int unsigned gap_odds = 0;
	int unsigned stall_odds = 0;
	int unsigned stall_hold = 0;
	int unsigned quiet_cycles = 0;
	int unsigned fail_count = 0;
	int unsigned pairs_sent = 0;
	int unsigned reports_checked = 0;
	int unsigned reg_writes = 0;
	int unsigned saturated_reports = 0;
	int unsigned limit_reports = 0;

	tacho_rpm_deadband_duty_controller_unit #(.SAMPLES(SAMPLES_DEF)) DUT (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Speed from a block sum: integer average, then the fixed numerator over it.
	// A zero average and any quotient above the 16-bit range both give the maximum.
	function automatic logic [RPM_W-1:0] speed_from_sum(input logic [SUM_W-1:0] total);
		int unsigned mean;
		int unsigned quotient;
		mean = total / SAMPLES_DEF;
		if (mean == 0)
			return RPM_MAX;
		quotient = RPM_NUMERATOR / mean;
		return (quotient > RPM_MAX) ? RPM_MAX : RPM_W'(quotient);
	endfunction

	// One deadband step: slowing down takes priority, and each direction has its limit.
	function automatic logic [DUTY_W-1:0] step_duty(input logic [DUTY_W-1:0] duty,
		input logic [RPM_W-1:0] speed, input logic [TARGET_W-1:0] target);
		int unsigned measured;
		int unsigned wanted;
		measured = speed;
		wanted = target;
		if (measured > wanted + DEADBAND && duty > DUTY_LOW)
			return duty - DUTY_STEP;
		if (measured + DEADBAND < wanted && duty < DUTY_HIGH)
			return duty + DUTY_STEP;
		return duty;
	endfunction

	// A constant period that reads back as exactly the given speed. For speeds from
	// 31 to 255 the round trip through the two divisions is exact.
	function automatic logic [PERIOD_W-1:0] period_for_rpm(input int unsigned speed);
		int unsigned aim;
		aim = (speed < 31) ? 31 : ((speed > 255) ? 255 : speed);
		return PERIOD_W'(RPM_NUMERATOR / aim);
	endfunction

	// A period that lands within a few rpm of the target, so that both deadband edges
	// and the steps on either side are hit. Targets below 38 get speeds from 31 to 45.
	function automatic logic [PERIOD_W-1:0] near_target(input logic [TARGET_W-1:0] target);
		int unsigned aim;
		aim = (target < 38) ? $urandom_range(31, 45) : target - 7 + $urandom_range(0, 14);
		return period_for_rpm(aim);
	endfunction

	function automatic aim_t pick_aim();
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (roll < 10)
			return AIM_DEADBAND;
		if (roll < 15)
			return AIM_ANY;
		if (roll < 17)
			return AIM_TINY;
		return AIM_SLOW;
	endfunction

	function automatic logic [PERIOD_W-1:0] draw_period(input aim_t aim,
		input logic [PERIOD_W-1:0] center);
		case (aim)
			AIM_DEADBAND: return center;
			AIM_TINY: return PERIOD_W'($urandom_range(0, 40));
			AIM_SLOW: return PERIOD_W'($urandom_range(40000, 65535));
			default: return PERIOD_W'($urandom);
		endcase
	endfunction

	// Targets lean toward the extremes, including those too low for a step up.
	function automatic logic [TARGET_W-1:0] pick_target();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return TARGET_W'($urandom_range(1, 3));
			2: return '1;
			3: return TARGET_W'($urandom_range(31, 60));
			default: return TARGET_W'($urandom);
		endcase
	endfunction

	// Adds one pair of periods to the shadow sums. The pair that completes a block
	// produces the expected speed report and advances both shadow duties.
	task automatic fold_in_periods(input in_item_t pair);
		out_item_t report;
		acc_left = acc_left + pair.left_period;
		acc_right = acc_right + pair.right_period;
		if (fill_count + 1 < SAMPLES_DEF) begin
			fill_count++;
			return;
		end
		report.rpm_left = speed_from_sum(acc_left);
		report.rpm_right = speed_from_sum(acc_right);
		acc_left = '0;
		acc_right = '0;
		fill_count = 0;
		duty_left_now = step_duty(duty_left_now, report.rpm_left, target_left);
		duty_right_now = step_duty(duty_right_now, report.rpm_right, target_right);
		report.duty_left = duty_left_now;
		report.duty_right = duty_right_now;
		due_reports.push_back(report);
	endtask

	// Sends one pair of periods, sometimes after an idle burst. Valid stays high from one
	// transaction to the next when there is no burst, so it never drops for a single step.
	// The stall is read right at the clock edge, which gives the value the block saw.
	task automatic push_periods(input logic [PERIOD_W-1:0] left_p,
		input logic [PERIOD_W-1:0] right_p);
		in_item_t pair;
		pair.left_period = left_p;
		pair.right_period = right_p;
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= pair;
		do @(posedge clk); while (in_stall);
		fold_in_periods(pair);
		pairs_sent++;
	endtask

	task automatic push_block(input logic [PERIOD_W-1:0] left_p,
		input logic [PERIOD_W-1:0] right_p);
		repeat (SAMPLES_DEF) push_periods(left_p, right_p);
	endtask

	// Register writes only happen once the block is idle, so the shadow copy of the
	// targets can change at the moment the write is taken.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
		input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
		if (index == REG_DESIRED_LEFT)
			target_left = value;
		else if (index == REG_DESIRED_RIGHT)
			target_right = value;
	endtask

	// Stops sending and waits until every awaited report has come back. The extra pause
	// lets a computation that yields nothing, or a stray extra report, show itself.
	task automatic settle();
		in_valid <= 1'b0;
		while (due_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random stream of well-formed blocks. Each wheel picks how to draw its periods at the
	// start of every block: mostly right at the deadband, sometimes anything, sometimes
	// tiny periods for the saturated speed, sometimes long periods for slow wheels.
	task automatic stream_mixed(input int unsigned count);
		aim_t aim_l;
		aim_t aim_r;
		logic [PERIOD_W-1:0] center_l;
		logic [PERIOD_W-1:0] center_r;
		aim_l = AIM_ANY;
		aim_r = AIM_ANY;
		center_l = '0;
		center_r = '0;
		repeat (count) begin
			if (fill_count == 0) begin
				aim_l = pick_aim();
				aim_r = pick_aim();
				center_l = near_target(target_left);
				center_r = near_target(target_right);
			end
			push_periods(draw_period(aim_l, center_l), draw_period(aim_r, center_r));
		end
	endtask

	// Directed blocks at the reset targets. The first has a left sum below one average
	// step, which gives a zero average, and a right average of 30, just short enough to
	// saturate. The second has the largest period on the left and a right speed on the
	// upper deadband edge. The third steps the left duty down from just outside the band
	// and leaves the right one at the lower deadband edge.
	task automatic test_special_blocks();
		gap_odds = 3;
		stall_odds = 4;
		for (int i = 0; i < SAMPLES_DEF; i++)
			push_periods((i == 0) ? PERIOD_W'(9) : '0, PERIOD_W'(30));
		push_block('1, period_for_rpm(TARGET_RESET + DEADBAND));
		push_block(period_for_rpm(TARGET_RESET + DEADBAND + 1),
			period_for_rpm(TARGET_RESET - DEADBAND));
	endtask

	// Writes to indexes past the last register must leave both targets alone. The block
	// that follows steps the left duty up and the right one down only if they still hold.
	task automatic test_ignored_register();
		settle();
		write_reg(REG_DESIRED_RIGHT + 1'b1, 8'hAA);
		write_reg('1, 8'h55);
		write_reg(CFG_IDX_W'($urandom_range(REG_DESIRED_RIGHT + 2, 254)), CFG_DATA_W'($urandom));
		push_block(period_for_rpm(TARGET_RESET - DEADBAND - 1),
			period_for_rpm(TARGET_RESET + DEADBAND + 1));
	endtask

	// Several phases, each with its own targets and its own mix of idling on both sides.
	// The first two phases put the targets at opposite extremes. Phase lengths are often not
	// whole blocks, so a partly filled block may span a change of targets.
	task automatic test_random_targets();
		for (int phase = 0; phase < 8; phase++) begin
			settle();
			if (phase < 2) begin
				write_reg(REG_DESIRED_LEFT, (phase == 0) ? '0 : '1);
				write_reg(REG_DESIRED_RIGHT, (phase == 0) ? '1 : '0);
			end else if ($urandom_range(0, 1) == 0) begin
				write_reg(REG_DESIRED_LEFT, pick_target());
				write_reg(REG_DESIRED_RIGHT, pick_target());
			end else begin
				write_reg(REG_DESIRED_RIGHT, pick_target());
				write_reg(CFG_IDX_W'($urandom_range(REG_DESIRED_RIGHT + 1, 255)),
					CFG_DATA_W'($urandom));
				write_reg(REG_DESIRED_LEFT, pick_target());
			end
			gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
			stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
			stream_mixed($urandom_range(20, 40));
		end
	endtask

	// With the top target and slow wheels both duties climb until they stop at the ceiling,
	// then a few more blocks confirm that they stay there.
	task automatic test_duty_ceiling();
		settle();
		write_reg(REG_DESIRED_LEFT, '1);
		write_reg(REG_DESIRED_RIGHT, '1);
		gap_odds = 8;
		stall_odds = 6;
		while (duty_left_now < DUTY_HIGH || duty_right_now < DUTY_HIGH)
			push_periods(PERIOD_W'($urandom_range(40000, 65535)),
				PERIOD_W'($urandom_range(40000, 65535)));
		repeat (3 * SAMPLES_DEF)
			push_periods(PERIOD_W'($urandom_range(40000, 65535)),
				PERIOD_W'($urandom_range(40000, 65535)));
	endtask

	// With a zero target every measured speed is too fast, so both duties fall to the floor.
	task automatic test_duty_floor();
		settle();
		write_reg(REG_DESIRED_LEFT, '0);
		write_reg(REG_DESIRED_RIGHT, '0);
		gap_odds = 8;
		stall_odds = 6;
		while (duty_left_now > DUTY_LOW || duty_right_now > DUTY_LOW)
			push_periods(PERIOD_W'($urandom_range(100, 60000)),
				PERIOD_W'($urandom_range(100, 60000)));
		repeat (3 * SAMPLES_DEF)
			push_periods(PERIOD_W'($urandom_range(100, 60000)),
				PERIOD_W'($urandom_range(100, 60000)));
	endtask

	// Closing stretch at full rate: no idle bursts on either side, so the queue fills
	// and the input stall is exercised back to back.
	task automatic test_steady_stream();
		settle();
		write_reg(REG_DESIRED_LEFT, pick_target());
		write_reg(REG_DESIRED_RIGHT, pick_target());
		gap_odds = 0;
		stall_odds = 0;
		stream_mixed(150);
	endtask

	// Output stall in bursts. A burst keeps the stall high until its
	// count runs out; otherwise a new burst starts with the current odds.
	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
			out_stall <= 1'b1;
			stall_hold <= $urandom_range(0, 18);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Every accepted report is compared field by field with the oldest expectation.
	always @(posedge clk) begin : check_reports
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_reports.size() == 0) begin
				$error("speed report with nothing awaited: %p", out_data);
				fail_count++;
			end else begin
				want = due_reports.pop_front();
				reports_checked++;
				if (want.rpm_left == RPM_MAX || want.rpm_right == RPM_MAX)
					saturated_reports++;
				if (want.duty_left <= DUTY_LOW || want.duty_left >= DUTY_HIGH ||
					want.duty_right <= DUTY_LOW || want.duty_right >= DUTY_HIGH)
					limit_reports++;
				if (out_data.rpm_left !== want.rpm_left) begin
					$error("rpm_left: expected %0d, got %0d", want.rpm_left, out_data.rpm_left);
					fail_count++;
				end
				if (out_data.rpm_right !== want.rpm_right) begin
					$error("rpm_right: expected %0d, got %0d", want.rpm_right, out_data.rpm_right);
					fail_count++;
				end
				if (out_data.duty_left !== want.duty_left) begin
					$error("duty_left: expected %0d, got %0d", want.duty_left, out_data.duty_left);
					fail_count++;
				end
				if (out_data.duty_right !== want.duty_right) begin
					$error("duty_right: expected %0d, got %0d", want.duty_right,
						out_data.duty_right);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: any transaction on any channel restarts the count of quiet cycles.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
				$display("tb: failure");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// The floor is reached first from near the reset duty, which keeps the full climb
	// to the ceiling as the only long traversal of the duty range.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_blocks();
		test_ignored_register();
		test_duty_floor();
		test_random_targets();
		test_duty_ceiling();
		test_steady_stream();
		settle();
		$display("sent %0d period pairs, checked %0d speed reports, made %0d register writes",
			pairs_sent, reports_checked, reg_writes);
		$display("%0d reports had a saturated speed, %0d had a duty at a limit",
			saturated_reports, limit_reports);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/tdrc_pkg.sv
src/tdrc_front.sv
src/tdrc_fifo.sv
src/tdrc_div.sv
src/tdrc_back.sv
src/tacho_rpm_deadband_duty_controller_unit.sv
src/tdrc_checker.sv
verif/tacho_rpm_deadband_duty_controller_unit_tb.sv
